// ----- rtl/core/tea_pkg.sv -----
package tea_pkg;

	localparam int unsigned ROUND_COUNT = 32;
	localparam int unsigned WORD_W      = 32;
	localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_A = 2'd0,
		CFG_KEY_B = 2'd1,
		CFG_KEY_C = 2'd2,
		CFG_KEY_D = 2'd3
	} tea_cfg_idx_t;

	// action codes
	localparam logic ACT_ENCRYPT = 1'b0;
	localparam logic ACT_DECRYPT = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] d;
	} tea_key_t;

	// one slot of the round chain
	typedef struct packed {
		logic              vld;
		logic              act;
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] z;
	} tea_lane_t;

	// TEA mixing term of one half round
	function automatic logic [WORD_W-1:0] tea_mix(
		input logic [WORD_W-1:0] w,
		input logic [WORD_W-1:0] s,
		input logic [WORD_W-1:0] kl,
		input logic [WORD_W-1:0] kr
	);
		logic [WORD_W-1:0] shl;
		logic [WORD_W-1:0] shr;
		shl = w << 4;
		shr = w >> 5;
		return (shl + kl) ^ (w + s) ^ (shr + kr);
	endfunction

	// running sum seen by round i when encrypting
	function automatic logic [WORD_W-1:0] enc_sum(input int unsigned i);
		return WORD_W'(TEA_DELTA * WORD_W'(i + 1));
	endfunction

	// running sum seen by round i when decrypting
	function automatic logic [WORD_W-1:0] dec_sum(input int unsigned i);
		return WORD_W'(TEA_DELTA * WORD_W'(ROUND_COUNT - i));
	endfunction

endpackage

// ----- rtl/core/tea_in_if.sv -----
interface tea_in_if;
	import tea_pkg::*;

	logic              valid;
	logic              ready;
	logic              action;
	logic [WORD_W-1:0] block_first;
	logic [WORD_W-1:0] block_second;

	modport source(output valid, action, block_first, block_second, input ready);
	modport sink(input valid, action, block_first, block_second, output ready);

endinterface

// ----- rtl/core/tea_out_if.sv -----
interface tea_out_if;
	import tea_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] out_first;
	logic [WORD_W-1:0] out_second;

	modport source(output valid, out_first, out_second, input ready);
	modport sink(input valid, out_first, out_second, output ready);

endinterface

// ----- rtl/core/tea_cell.sv -----
module tea_cell
	import tea_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  tea_key_t          key,
	input  logic [WORD_W-1:0] sum_enc,
	input  logic [WORD_W-1:0] sum_dec,
	input  tea_lane_t         lane_i,
	output tea_lane_t         lane_o
);

	logic              vld_s1, vld_s2;
	logic              act_s1, act_s2;
	logic [WORD_W-1:0] y_s1, z_s1, y_s2, z_s2;

	logic [WORD_W-1:0] mix1, mix2;
	logic [WORD_W-1:0] y_nxt1, z_nxt1, y_nxt2, z_nxt2;

	// first half: encrypt updates y from z, decrypt updates z from y
	always_comb begin
		y_nxt1 = lane_i.y;
		z_nxt1 = lane_i.z;
		if (lane_i.act == ACT_DECRYPT) begin
			mix1   = tea_mix(lane_i.y, sum_dec, key.c, key.d);
			z_nxt1 = lane_i.z - mix1;
		end else begin
			mix1   = tea_mix(lane_i.z, sum_enc, key.a, key.b);
			y_nxt1 = lane_i.y + mix1;
		end
	end

	// second half: encrypt updates z from new y, decrypt updates y from new z
	always_comb begin
		y_nxt2 = y_s1;
		z_nxt2 = z_s1;
		if (act_s1 == ACT_DECRYPT) begin
			mix2   = tea_mix(z_s1, sum_dec, key.a, key.b);
			y_nxt2 = y_s1 - mix2;
		end else begin
			mix2   = tea_mix(y_s1, sum_enc, key.c, key.d);
			z_nxt2 = z_s1 + mix2;
		end
	end

	// advance occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= lane_i.vld;
			vld_s2 <= vld_s1;
		end
	end

	// advance payload, hold on stall
	always_ff @(posedge clk) begin
		if (en) begin
			act_s1 <= lane_i.act;
			y_s1   <= y_nxt1;
			z_s1   <= z_nxt1;
			act_s2 <= act_s1;
			y_s2   <= y_nxt2;
			z_s2   <= z_nxt2;
		end
	end

	assign lane_o = '{vld: vld_s2, act: act_s2, y: y_s2, z: z_s2};

endmodule

// ----- rtl/core/tea_block_cipher.sv -----
// TEA block cipher, 32 rounds, one 64-bit block per transfer.
// din carries action (0 encrypt, 1 decrypt) and the block as block_first and
// block_second; dout returns out_first and out_second. Both are valid/ready
// channels; a transfer happens on a rising clk edge with valid and ready high.
// The 128-bit key sits in four registers written through cfg_we, cfg_index
// and cfg_data (index 0 to 3 for key words a to d); write them only while no
// block is in flight.
// Each round is one cell of a chain, split into two registered half rounds,
// giving 2 * ROUND_COUNT (64) slots; a block passes through all of them
// between the din transfer and dout.valid. A new block is taken every cycle
// while dout does not stall: the rounds are fully unrolled, so throughput is
// one block per clock; the half-round adder chain between cell registers
// sets the clock period.
// When the receiver stalls, the whole chain holds and din.ready drops while
// the finished block waits at dout; empty slots do not close up during the
// stall.
// Reset (arst_n low) empties the chain and clears the key to zero.
module tea_block_cipher
	import tea_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	tea_in_if.sink               din,
	tea_out_if.source            dout,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	tea_key_t  key_q;
	tea_lane_t lane [ROUND_COUNT+1];
	logic      en;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			unique case (tea_cfg_idx_t'(cfg_index))
				CFG_KEY_A: key_q.a <= cfg_data;
				CFG_KEY_B: key_q.b <= cfg_data;
				CFG_KEY_C: key_q.c <= cfg_data;
				CFG_KEY_D: key_q.d <= cfg_data;
				default:   key_q   <= key_q;
			endcase
		end
	end

	// advance the chain unless a finished block waits unclaimed
	assign en        = !lane[ROUND_COUNT].vld || dout.ready;
	assign din.ready = en;

	assign lane[0] = '{vld: din.valid, act: din.action,
	                   y: din.block_first, z: din.block_second};

	// chain of round cells
	for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
		tea_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.key    (key_q),
			.sum_enc(enc_sum(g)),
			.sum_dec(dec_sum(g)),
			.lane_i (lane[g]),
			.lane_o (lane[g+1])
		);
	end

	assign dout.valid      = lane[ROUND_COUNT].vld;
	assign dout.out_first  = lane[ROUND_COUNT].y;
	assign dout.out_second = lane[ROUND_COUNT].z;

	// a result shows up only after the chain has moved
	a_valid_after_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dout.valid) |-> $past(en))
		else $error("dout.valid rose without the chain advancing");

	// a stalled chain keeps the first cell's output occupancy and the output word y
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(g_round[0].u_cell.lane_o.vld) && $stable(lane[ROUND_COUNT].y))
		else $error("chain moved during a stall");

	// a key write to index 0 lands in key word a
	a_key_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == CFG_KEY_A |=> key_q.a == $past(cfg_data))
		else $error("key word a not updated by write");

endmodule
